// File: sv/isk_pkg.sv
package isk_pkg;

	// pool geometry
	localparam int POOL_LOG2 = 8;
	localparam int POOL_SIZE = 1 << POOL_LOG2;
	localparam int BLK_W     = POOL_LOG2 - 3;

	typedef logic [POOL_LOG2-1:0] idx_t;
	typedef logic [BLK_W-1:0]     blk_t;

	localparam idx_t POOL_HALF = idx_t'(POOL_SIZE >> 1);
	localparam blk_t BLK_LAST  = blk_t'((POOL_SIZE >> 3) - 1);

	// item kinds carried in s_tuser
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_INIT = 2'd1;
	localparam logic [1:0] MODE_WORD = 2'd2;

	localparam logic [31:0] GOLDEN = 32'h9e3779b9;

	// eight-word mixing state
	typedef logic [7:0][31:0] mix_state_t;

	// commands from the sequencer to the mixer
	typedef struct packed {
		logic        load_golden;
		logic        add_en;
		logic [2:0]  add_k;
		logic [31:0] add_word;
		logic        scr_en;
		logic [2:0]  scr_line;
	} mix_cmd_t;

	// sequencer states
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_GOLD = 8'b0000_0010,
		ST_ADD  = 8'b0000_0100,
		ST_SCR  = 8'b0000_1000,
		ST_WR   = 8'b0001_0000,
		ST_WB   = 8'b0010_0000,
		ST_WC   = 8'b0100_0000,
		ST_WD   = 8'b1000_0000
	} state_t;

endpackage

// File: sv/isaac_keystream_generator.sv
// ISAAC 32-bit keystream generator with a pool of isk_pkg::POOL_SIZE words (256 by default).
// Items arrive on the s_ stream; s_tuser selects the kind: load writes one seed word into the
// seed/result store, init runs the golden-ratio mixing and fills the pool (with use_seed set,
// one pass over the seed store and one over the pool), and word returns the next random word
// on the m_ stream. Word items are meaningful only after an init. A load is written as it is
// accepted; a word takes its accept plus three dependent pool reads on the dual-read pool
// memory (registered reads) and waits longer only while an earlier word sits untaken in the
// output register; an init takes the accept and the golden mixing, then, per block of eight
// words and per pass, a scramble phase and a write phase, preceded by a read/add phase per
// block and pass when seeded (two passes). The seed store is cleared at reset through
// per-entry valid bits, so there is no clearing pass.
module isaac_keystream_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// seed_index [7:0], seed_word [39:8], use_seed [40], zero [47:41]
	input  logic [47:0] s_tdata,
	// mode [1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// random_word [31:0]
	output logic [31:0] m_tdata
);

	localparam int LG = isk_pkg::POOL_LOG2;

	// input fields
	logic [7:0]  seed_index;
	logic [31:0] seed_word;
	logic        use_seed;
	assign seed_index = s_tdata[7:0];
	assign seed_word  = s_tdata[39:8];
	assign use_seed   = s_tdata[40];

	// control state
	isk_pkg::state_t state_q;
	logic [4:0]      stp_q;
	isk_pkg::blk_t   blk_q;
	logic            pass_q;
	logic            use_seed_q;
	logic [31:0]     a_q;
	logic [31:0]     last_b_q;
	logic [31:0]     pc_q;
	isk_pkg::idx_t   step_q;
	logic            out_vld_q;
	logic [isk_pkg::POOL_SIZE-1:0] seed_vld_q;

	// word datapath
	logic [31:0] bb_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic        fwd_q;
	logic [31:0] out_q;

	// memories
	logic [31:0] pool_mem [isk_pkg::POOL_SIZE];
	logic [31:0] seed_mem [isk_pkg::POOL_SIZE];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;
	logic [31:0] seed_rd_q;
	logic        seed_rv_q;

	logic          acc;
	logic          acc_load;
	logic          acc_init;
	logic          acc_word;
	logic          wd_done;
	isk_pkg::idx_t blk_addr;
	logic          add_issue;

	isk_pkg::idx_t addr_a;
	logic          rd_a_en;
	logic          rd_b_en;
	logic          pool_we;
	isk_pkg::idx_t pool_wa;
	logic [31:0]   pool_wd;
	logic          seed_we;
	isk_pkg::idx_t seed_wa;
	logic [31:0]   seed_wd;
	logic          seed_re;

	logic [31:0]   sh;
	logic [31:0]   a_next;
	logic [31:0]   y_c;
	isk_pkg::idx_t y_idx;
	logic [31:0]   b_new;
	logic [31:0]   seed_src;

	isk_pkg::mix_cmd_t   mcmd;
	isk_pkg::mix_state_t mix_s;

	assign s_tready = (state_q == isk_pkg::ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign acc_load = acc && (s_tuser == isk_pkg::MODE_LOAD);
	assign acc_init = acc && (s_tuser == isk_pkg::MODE_INIT);
	assign acc_word = acc && (s_tuser == isk_pkg::MODE_WORD);

	// a finished word leaves only when the output register is free
	assign wd_done = (state_q == isk_pkg::ST_WD) && (!out_vld_q || m_tready);

	// block-relative address used by the fill passes
	assign blk_addr  = {blk_q, stp_q[2:0]};
	assign add_issue = (state_q == isk_pkg::ST_ADD) && !stp_q[3];

	// word step arithmetic
	always_comb begin
		unique case (step_q[1:0])
			2'd0: sh = a_q << 13;
			2'd1: sh = a_q >> 6;
			2'd2: sh = a_q << 2;
			2'd3: sh = a_q >> 16;
			default: sh = '0;
		endcase
	end
	assign a_next   = (a_q ^ sh) + rd_b_q;
	assign y_c      = rd_a_q + a_q + bb_q;
	assign y_idx    = y_c[2*LG+1:LG+2];
	// last lookup may land on the entry just written
	assign b_new    = (fwd_q ? y_q : rd_a_q) + x_q;
	assign seed_src = seed_rv_q ? seed_rd_q : 32'd0;

	// pool port a: own entry, then the two indirect lookups, or fill-pass reads
	always_comb begin
		priority case (1'b1)
			(state_q == isk_pkg::ST_WB):  addr_a = rd_a_q[LG+1:2];
			(state_q == isk_pkg::ST_WC):  addr_a = y_idx;
			(state_q == isk_pkg::ST_ADD): addr_a = blk_addr;
			default:                      addr_a = step_q;
		endcase
	end
	assign rd_a_en = acc_word || (add_issue && pass_q) ||
		(state_q == isk_pkg::ST_WB) || (state_q == isk_pkg::ST_WC);
	assign rd_b_en = acc_word;

	// pool write: word result or fill-pass block
	assign pool_we = (state_q == isk_pkg::ST_WC) || (state_q == isk_pkg::ST_WR);
	assign pool_wa = (state_q == isk_pkg::ST_WC) ? step_q : blk_addr;
	assign pool_wd = (state_q == isk_pkg::ST_WC) ? y_c : mix_s[stp_q[2:0]];

	// seed/result store
	assign seed_we = acc_load || wd_done;
	assign seed_wa = acc_load ? isk_pkg::idx_t'(seed_index) : step_q;
	assign seed_wd = acc_load ? seed_word : b_new;
	assign seed_re = add_issue && !pass_q;

	always_ff @(posedge clk) begin
		if (pool_we) begin
			pool_mem[pool_wa] <= pool_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			rd_a_q <= pool_mem[addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_b_en) begin
			rd_b_q <= pool_mem[step_q ^ isk_pkg::POOL_HALF];
		end
	end

	always_ff @(posedge clk) begin
		if (seed_we) begin
			seed_mem[seed_wa] <= seed_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (seed_re) begin
			seed_rd_q <= seed_mem[blk_addr];
			seed_rv_q <= seed_vld_q[blk_addr];
		end
	end

	// mixer commands
	always_comb begin
		mcmd             = '0;
		mcmd.load_golden = acc_init;
		mcmd.add_en      = (state_q == isk_pkg::ST_ADD) && (stp_q[3:0] != 4'd0);
		mcmd.add_k       = stp_q[2:0] - 3'd1;
		mcmd.add_word    = pass_q ? rd_a_q : seed_src;
		mcmd.scr_en      = (state_q == isk_pkg::ST_GOLD) || (state_q == isk_pkg::ST_SCR);
		mcmd.scr_line    = stp_q[2:0];
	end

	isk_mixer u_mixer (
		.clk (clk),
		.cmd (mcmd),
		.s   (mix_s)
	);

	// sequencer and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= isk_pkg::ST_IDLE;
			stp_q      <= '0;
			blk_q      <= '0;
			pass_q     <= 1'b0;
			use_seed_q <= 1'b0;
			a_q        <= '0;
			last_b_q   <= '0;
			pc_q       <= '0;
			step_q     <= '0;
			out_vld_q  <= 1'b0;
			seed_vld_q <= '0;
		end else begin
			if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (seed_we) begin
				seed_vld_q[seed_wa] <= 1'b1;
			end
			unique case (state_q)
				isk_pkg::ST_IDLE: begin
					if (acc_init) begin
						state_q    <= isk_pkg::ST_GOLD;
						stp_q      <= '0;
						blk_q      <= '0;
						pass_q     <= 1'b0;
						use_seed_q <= use_seed;
						a_q        <= '0;
						last_b_q   <= '0;
						pc_q       <= '0;
						step_q     <= '0;
					end else if (acc_word) begin
						state_q <= isk_pkg::ST_WB;
						// counter bumps at the start of each pass
						if (step_q == '0) begin
							pc_q <= pc_q + 32'd1;
						end
					end
				end
				isk_pkg::ST_GOLD: begin
					stp_q <= stp_q + 5'd1;
					if (stp_q == 5'd31) begin
						stp_q   <= '0;
						state_q <= use_seed_q ? isk_pkg::ST_ADD : isk_pkg::ST_SCR;
					end
				end
				isk_pkg::ST_ADD: begin
					stp_q <= stp_q + 5'd1;
					if (stp_q[3]) begin
						stp_q   <= '0;
						state_q <= isk_pkg::ST_SCR;
					end
				end
				isk_pkg::ST_SCR: begin
					stp_q <= stp_q + 5'd1;
					if (stp_q[2:0] == 3'd7) begin
						stp_q   <= '0;
						state_q <= isk_pkg::ST_WR;
					end
				end
				isk_pkg::ST_WR: begin
					stp_q <= stp_q + 5'd1;
					if (stp_q[2:0] == 3'd7) begin
						stp_q <= '0;
						if (blk_q == isk_pkg::BLK_LAST) begin
							blk_q <= '0;
							if (use_seed_q && !pass_q) begin
								pass_q  <= 1'b1;
								state_q <= isk_pkg::ST_ADD;
							end else begin
								state_q <= isk_pkg::ST_IDLE;
							end
						end else begin
							blk_q   <= blk_q + 1'b1;
							state_q <= use_seed_q ? isk_pkg::ST_ADD : isk_pkg::ST_SCR;
						end
					end
				end
				isk_pkg::ST_WB: begin
					a_q     <= a_next;
					state_q <= isk_pkg::ST_WC;
				end
				isk_pkg::ST_WC: begin
					state_q <= isk_pkg::ST_WD;
				end
				isk_pkg::ST_WD: begin
					if (wd_done) begin
						out_vld_q <= 1'b1;
						last_b_q  <= b_new;
						step_q    <= step_q + 1'b1;
						state_q   <= isk_pkg::ST_IDLE;
					end
				end
				default: state_q <= isk_pkg::ST_IDLE;
			endcase
		end
	end

	// word datapath registers
	always_ff @(posedge clk) begin
		if (acc_word) begin
			bb_q <= last_b_q + ((step_q == '0) ? (pc_q + 32'd1) : 32'd0);
		end
		if (state_q == isk_pkg::ST_WB) begin
			x_q <= rd_a_q;
		end
		if (state_q == isk_pkg::ST_WC) begin
			y_q   <= y_c;
			fwd_q <= (y_idx == step_q);
		end
		if (wd_done) begin
			out_q <= b_new;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// a word item goes straight into its lookup sequence
	a_word_seq: assert property (@(posedge clk) disable iff (!arst_n)
		acc_word |=> (state_q == isk_pkg::ST_WB))
		else $error("word item did not start its lookup sequence");

	// pool is written only by the result step or the fill write phase
	a_pool_we: assert property (@(posedge clk) disable iff (!arst_n)
		pool_we |-> (state_q == isk_pkg::ST_WC || state_q == isk_pkg::ST_WR))
		else $error("pool written outside a write phase");

	// a delivered word advances the step index by one
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		wd_done |=> (step_q == isk_pkg::idx_t'($past(step_q) + 1'b1)))
		else $error("step index did not advance after a word");

	// a finished word never overwrites one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready && state_q == isk_pkg::ST_WD) |=>
		(state_q == isk_pkg::ST_WD && out_vld_q))
		else $error("pending result overwritten");

endmodule

// File: sv/isk_mixer.sv
module isk_mixer (
	input  logic                clk,
	input  isk_pkg::mix_cmd_t   cmd,
	output isk_pkg::mix_state_t s
);

	isk_pkg::mix_state_t s_q;

	// one line of the scramble: xor-shift, then two adds
	function automatic isk_pkg::mix_state_t scramble_line(
		input isk_pkg::mix_state_t v,
		input logic [2:0]          l
	);
		isk_pkg::mix_state_t r;
		logic [2:0]          k1;
		logic [2:0]          k2;
		logic [2:0]          k3;
		logic [31:0]         sh;
		r  = v;
		k1 = l + 3'd1;
		k2 = l + 3'd2;
		k3 = l + 3'd3;
		unique case (l)
			3'd0: sh = v[k1] << 11;
			3'd1: sh = v[k1] >> 2;
			3'd2: sh = v[k1] << 8;
			3'd3: sh = v[k1] >> 16;
			3'd4: sh = v[k1] << 10;
			3'd5: sh = v[k1] >> 4;
			3'd6: sh = v[k1] << 8;
			3'd7: sh = v[k1] >> 9;
			default: sh = '0;
		endcase
		r[l]  = v[l] ^ sh;
		r[k3] = v[k3] + r[l];
		r[k1] = v[k1] + v[k2];
		return r;
	endfunction

	always_ff @(posedge clk) begin
		priority if (cmd.load_golden) begin
			s_q <= {8{isk_pkg::GOLDEN}};
		end else if (cmd.add_en) begin
			s_q[cmd.add_k] <= s_q[cmd.add_k] + cmd.add_word;
		end else if (cmd.scr_en) begin
			s_q <= scramble_line(s_q, cmd.scr_line);
		end
	end

	assign s = s_q;

endmodule
